>>> sv/rapi_message_checker_assert.svh
// assertion macros shared by the checker of the command line checker
// needs clk and arst_n in the scope where a macro is used
`ifndef RAPI_MESSAGE_CHECKER_ASSERT_SVH
`define RAPI_MESSAGE_CHECKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RMC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmc assertion failed");

// next-cycle implication, disabled during reset
`define RMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmc assertion failed");

`endif

>>> sv/rmc_pkg.sv
// types, character codes and constants of the command line checker
// no dependencies
`default_nettype none

package rmc_pkg;

	// characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;

	localparam logic [15:0] BOOT_CMD = {CH_A, CH_B};

	// configuration
	localparam int CFG_IDX_W = 2;
	localparam logic [7:0] START_CHAR_RST = 8'd36;
	localparam logic [3:0] MAX_TOKENS_RST = 4'd10;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_CHAR = 2'd0,
		CFG_MAX_TOKENS = 2'd1
	} cfg_idx_t;

	// result codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_UNKNOWN = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CK_NONE = 2'd0,
		CK_ADD  = 2'd1,
		CK_XOR  = 2'd2
	} check_t;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// one classified character
	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
		logic       is_space;
		check_t     mark;
		logic       hex_ok;
		logic [3:0] hex_val;
	} rmc_item_t;

endpackage

`default_nettype wire

>>> sv/rmc_char_if.sv
// input channel: one character item per handshake
// no dependencies
`default_nettype none

interface rmc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last_char;

	modport source (output valid, output char_in, output last_char, input ready);
	modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

`default_nettype wire

>>> sv/rmc_result_if.sv
// result channel: one result item per checked line
// depends on rmc_pkg
`default_nettype none

interface rmc_result_if;
	logic             valid;
	logic             ready;
	rmc_pkg::status_t status;
	rmc_pkg::check_t  check_kind;
	logic [3:0]       token_total;
	logic             boot_request;
	logic [15:0]      command_code;

	modport source (output valid, output status, output check_kind, output token_total,
		output boot_request, output command_code, input ready);
	modport sink   (input valid, input status, input check_kind, input token_total,
		input boot_request, input command_code, output ready);
endinterface

`default_nettype wire

>>> sv/rmc_cfg_if.sv
// configuration write channel: register index and write data
// depends on rmc_pkg
`default_nettype none

interface rmc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [rmc_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/rapi_message_checker.sv
// Command line checker. Characters of one ASCII command line arrive one item
// per character on chars, the final one flagged by last_char; one result item
// per line leaves on results. The first character is a start mark and is
// skipped; additive and xor 8-bit sums are seeded with start_char, tokens are
// counted at spaces up to max_tokens, and a '*' or '^' followed by two hex
// digits selects and checks the additive or xor sum. The result gives status,
// check kind, token count, a boot request flag for command AB and the first
// two command characters. Throughput is one character per clock while the queue
// is not full: the front classifies a character in the cycle it is accepted and
// writes it to a two-entry queue, and the back end updates the line state for
// one character per cycle. A result passes the queue and the result register
// before it shows on results; while it waits to be taken, characters of the
// next line keep flowing until that line's last character reaches the back end.
// There is no clearing pass after reset. Configuration writes on cfg are always
// ready and should be issued only while no line is in progress.
// depends on rmc_pkg, the channel interfaces, rmc_front, rmc_queue and rmc_back
`default_nettype none

module rapi_message_checker (
	input  logic         clk,
	input  logic         arst_n,
	rmc_char_if.sink     chars,
	rmc_result_if.source results,
	rmc_cfg_if.sink      cfg
);
	import rmc_pkg::*;

	// configuration registers
	logic [7:0] start_char_q;
	logic [3:0] max_tokens_q;

	// front to queue
	logic      push;
	rmc_item_t push_item;
	logic      q_full;

	// queue to back
	logic      pop;
	logic      q_valid;
	rmc_item_t q_item;

	// writes go straight into the configuration registers, so the port never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_char_q <= START_CHAR_RST;
			max_tokens_q <= MAX_TOKENS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_START_CHAR: start_char_q <= cfg.data;
				CFG_MAX_TOKENS: max_tokens_q <= cfg.data[3:0];
				default: begin
				end
			endcase
		end
	end

	// classify each character as it is accepted
	rmc_front u_front (
		.chars     (chars),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decouples input acceptance from a stalled result
	rmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// line state, checksum verdict and result register
	rmc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_char (start_char_q),
		.max_tokens (max_tokens_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop),
		.results    (results)
	);

endmodule

`default_nettype wire

>>> sv/rmc_front.sv
// front: accepts characters and classifies them for the back end
// depends on rmc_pkg and rmc_char_if
`default_nettype none

module rmc_front (
	rmc_char_if.sink        chars,
	input  logic            q_full,
	output logic            push,
	output rmc_pkg::rmc_item_t push_item
);
	import rmc_pkg::*;

	logic [7:0] c;
	logic [7:0] diff;

	assign c = chars.char_in;
	assign chars.ready = !q_full;
	assign push = chars.valid && !q_full;

	always_comb begin
		push_item           = '0;
		push_item.char_in   = c;
		push_item.last_char = chars.last_char;
		push_item.is_space  = (c == CH_SPACE);
		push_item.mark      = CK_NONE;
		diff                = 8'd0;
		if (c == CH_STAR) begin
			push_item.mark = CK_ADD;
		end else if (c == CH_CARET) begin
			push_item.mark = CK_XOR;
		end
		case (c) inside
			[CH_ZERO:CH_NINE]: begin
				push_item.hex_ok = 1'b1;
				diff = c - CH_ZERO;
			end
			[CH_A:CH_UP_F]: begin
				push_item.hex_ok = 1'b1;
				diff = c - CH_A + 8'd10;
			end
			[CH_LO_A:CH_LO_F]: begin
				push_item.hex_ok = 1'b1;
				diff = c - CH_LO_A + 8'd10;
			end
			default: begin
				push_item.hex_ok = 1'b0;
			end
		endcase
		push_item.hex_val = diff[3:0];
	end

endmodule

`default_nettype wire

>>> sv/rmc_queue.sv
// short queue of classified characters between front and back
// depends on rmc_pkg
`default_nettype none

module rmc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rmc_pkg::rmc_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               q_valid,
	output rmc_pkg::rmc_item_t q_item
);
	import rmc_pkg::*;

	rmc_item_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/rmc_back.sv
// back: line state, checksum check and the result register
// depends on rmc_pkg and rmc_result_if
`default_nettype none

module rmc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         start_char,
	input  logic [3:0]         max_tokens,
	input  logic               q_valid,
	input  rmc_pkg::rmc_item_t q_item,
	output logic               pop,
	rmc_result_if.source       results
);
	import rmc_pkg::*;

	typedef enum logic [3:0] {
		POS_MARK   = 4'b0001,
		POS_FIRST  = 4'b0010,
		POS_SECOND = 4'b0100,
		POS_REST   = 4'b1000
	} pos_t;

	typedef enum logic [2:0] {
		PH_BODY = 3'b001,
		PH_HEX  = 3'b010,
		PH_SKIP = 3'b100
	} phase_t;

	pos_t        pos_q, n_pos;
	phase_t      phase_q, n_phase;
	logic [7:0]  add_q, n_add;
	logic [7:0]  xor_q, n_xor;
	logic [3:0]  tok_q, n_tok;
	check_t      chk_q, n_chk;
	logic [7:0]  hexv_q, n_hexv;
	logic [1:0]  hexn_q, n_hexn;
	logic        bad_q, n_bad;
	logic [15:0] cmd_q, n_cmd;

	logic        ok;
	status_t     st;
	logic        boot;

	logic        out_valid_q;
	status_t     status_q;
	check_t      check_kind_q;
	logic [3:0]  token_total_q;
	logic        boot_request_q;
	logic [15:0] command_code_q;

	logic [7:0]  c;
	assign c = q_item.char_in;

	// a last character waits while the result register is still held
	assign pop = q_valid && (!q_item.last_char || !out_valid_q || results.ready);

	// line state update for one character
	always_comb begin
		n_pos   = pos_q;
		n_phase = phase_q;
		n_add   = add_q;
		n_xor   = xor_q;
		n_tok   = tok_q;
		n_chk   = chk_q;
		n_hexv  = hexv_q;
		n_hexn  = hexn_q;
		n_bad   = bad_q;
		n_cmd   = cmd_q;
		case (pos_q)
			POS_MARK: begin
				n_add = start_char;
				n_xor = start_char;
				n_tok = 4'd1;
				n_pos = POS_FIRST;
			end
			POS_FIRST: begin
				n_add = add_q + c;
				n_xor = xor_q ^ c;
				n_cmd = {c, 8'h00};
				n_pos = POS_SECOND;
			end
			POS_SECOND, POS_REST: begin
				case (phase_q)
					PH_BODY: begin
						if (q_item.is_space) begin
							if (tok_q >= max_tokens) begin
								n_bad   = 1'b1;
								n_phase = PH_SKIP;
							end else begin
								n_add = add_q + c;
								n_xor = xor_q ^ c;
								n_tok = tok_q + 4'd1;
							end
						end else if (q_item.mark != CK_NONE) begin
							n_chk   = q_item.mark;
							n_phase = PH_HEX;
						end else begin
							n_add = add_q + c;
							n_xor = xor_q ^ c;
							if (pos_q == POS_SECOND) begin
								n_cmd = {cmd_q[15:8], c};
							end
						end
					end
					PH_HEX: begin
						if (!q_item.hex_ok) begin
							n_bad   = 1'b1;
							n_phase = PH_SKIP;
						end else begin
							n_hexv = {hexv_q[3:0], q_item.hex_val};
							n_hexn = hexn_q + 2'd1;
							if (hexn_q != 2'd0) begin
								n_phase = PH_SKIP;
							end
						end
					end
					PH_SKIP: begin
					end
					default: begin
					end
				endcase
				n_pos = POS_REST;
			end
			default: begin
			end
		endcase
	end

	// verdict on the line as it stands after this character
	always_comb begin
		ok   = !n_bad && (n_pos == POS_SECOND || n_pos == POS_REST);
		st   = ST_UNKNOWN;
		boot = 1'b0;
		if (ok && n_chk != CK_NONE) begin
			if (n_hexn < 2'd2) begin
				ok = 1'b0;
			end else if (n_chk == CK_ADD && n_hexv != n_add) begin
				ok = 1'b0;
			end else if (n_chk == CK_XOR && n_hexv != n_xor) begin
				ok = 1'b0;
			end
		end
		if (!ok) begin
			st = ST_INVALID;
		end else begin
			case (n_cmd[15:8])
				CH_A: begin
					if (n_cmd[7:0] == CH_B) begin
						st   = ST_OK;
						boot = 1'b1;
					end else if (n_cmd[7:0] == CH_T || n_cmd[7:0] == CH_N) begin
						st = ST_OK;
					end
				end
				CH_O, CH_N: begin
					st = ST_OK;
				end
				default: begin
					st = ST_UNKNOWN;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_MARK;
			phase_q <= PH_BODY;
			add_q   <= '0;
			xor_q   <= '0;
			tok_q   <= '0;
			chk_q   <= CK_NONE;
			hexv_q  <= '0;
			hexn_q  <= '0;
			bad_q   <= 1'b0;
			cmd_q   <= '0;
		end else if (pop) begin
			if (q_item.last_char) begin
				pos_q   <= POS_MARK;
				phase_q <= PH_BODY;
				add_q   <= '0;
				xor_q   <= '0;
				tok_q   <= '0;
				chk_q   <= CK_NONE;
				hexv_q  <= '0;
				hexn_q  <= '0;
				bad_q   <= 1'b0;
				cmd_q   <= '0;
			end else begin
				pos_q   <= n_pos;
				phase_q <= n_phase;
				add_q   <= n_add;
				xor_q   <= n_xor;
				tok_q   <= n_tok;
				chk_q   <= n_chk;
				hexv_q  <= n_hexv;
				hexn_q  <= n_hexn;
				bad_q   <= n_bad;
				cmd_q   <= n_cmd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && q_item.last_char) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.last_char) begin
			status_q       <= st;
			check_kind_q   <= n_chk;
			token_total_q  <= ok ? n_tok : 4'd0;
			boot_request_q <= boot;
			command_code_q <= n_cmd;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.status       = status_q;
	assign results.check_kind   = check_kind_q;
	assign results.token_total  = token_total_q;
	assign results.boot_request = boot_request_q;
	assign results.command_code = command_code_q;

endmodule

`default_nettype wire

>>> sv/rmc_checker.sv
// port-level checks on the result channel of the command line checker
// depends on rmc_pkg and rapi_message_checker_assert.svh; bound to the top level
`default_nettype none
`include "rapi_message_checker_assert.svh"

module rmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [3:0]  token_total,
	input logic        boot_request,
	input logic [15:0] command_code
);
	import rmc_pkg::*;

	// a held result keeps its command code
	`RMC_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(command_code))

	// an invalid line reports no tokens and no boot request
	`RMC_ASSERT_NOW(a_invalid_clear, out_valid && status == ST_INVALID, token_total == 4'd0 && !boot_request)

	// boot request only for an accepted AB command
	`RMC_ASSERT_NOW(a_boot_cmd, out_valid && boot_request, status == ST_OK && command_code == BOOT_CMD)

	// an accepted line has at least one token
	`RMC_ASSERT_NOW(a_ok_tokens, out_valid && status == ST_OK, token_total != 4'd0)

endmodule

bind rapi_message_checker rmc_checker u_rmc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.status       (results.status),
	.token_total  (results.token_total),
	.boot_request (results.boot_request),
	.command_code (results.command_code)
);

`default_nettype wire
